FILE: sv/psd_pkg.sv
// Shared types and constants for the prefixed UTF-8 string decoder.
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

   // Field widths
   localparam int BYTE_WIDTH       = 8;
   localparam int CODE_WIDTH       = 32;
   localparam int LENGTH_WIDTH_DEF = 32;

   // Length prefix: 7 data bits per byte, shift count saturates
   localparam int SHIFT_WIDTH = 6;
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_STEP  = 6'd7;
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_LIMIT = 6'd56;
   localparam logic [SHIFT_WIDTH-1:0] SHIFT_SAT   = 6'd63;

   // UTF-8 continuation payload bits
   localparam int CONT_BITS    = 6;
   localparam int PENDING_BITS = 3;

   // One decoded result
   typedef struct packed {
      logic [CODE_WIDTH-1:0] code_point;
      logic                  last_char;
      logic                  empty_string;
   } result_type;

endpackage

`default_nettype wire

FILE: sv/prefixed_utf8_string_decoder.sv
// Top level of the length-prefixed UTF-8 string decoder.
//
//   channel  | ports                                    | direction
//   ---------+------------------------------------------+----------
//   request  | req_valid, req_stall, req_data_byte      | in
//   response | rsp_valid, rsp_stall, rsp_code_point,    | out
//            | rsp_last_char, rsp_empty_string          |
//
// One request byte is taken every cycle unless req_stall is high; its response, if any,
// is decoded combinationally from the decoder state into the result buffer.
// A two-entry result buffer (main plus skid) raises req_stall only when both are full.
// Synchronous active-high reset returns to reading a length prefix and empties the buffer.
`timescale 1ns / 1ps
`default_nettype none

module prefixed_utf8_string_decoder #(
   parameter int LENGTH_WIDTH = psd_pkg::LENGTH_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic [psd_pkg::BYTE_WIDTH-1:0]   req_data_byte,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic [psd_pkg::CODE_WIDTH-1:0]   rsp_code_point,
   output      logic                             rsp_last_char,
   output      logic                             rsp_empty_string
);

   logic                req_accept;
   logic                dec_valid;
   logic                buf_full;
   psd_pkg::result_type dec_result;
   psd_pkg::result_type rsp_result;

   // Accept a request whenever the skid entry is free
   assign req_stall  = buf_full;
   assign req_accept = req_valid && !buf_full;

   psd_decoder #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_decoder (
      .clock        (clock),
      .reset        (reset),
      .step         (req_accept),
      .data_byte    (req_data_byte),
      .result_valid (dec_valid),
      .result       (dec_result)
   );

   psd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept && dec_valid),
      .push_data (dec_result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_result)
   );

   assign rsp_code_point   = rsp_result.code_point;
   assign rsp_last_char    = rsp_result.last_char;
   assign rsp_empty_string = rsp_result.empty_string;

endmodule

`default_nettype wire

FILE: sv/psd_decoder.sv
// Decode step: length prefix and UTF-8 state, one request byte per accept.
`timescale 1ns / 1ps
`default_nettype none

module psd_decoder #(
   parameter int LENGTH_WIDTH = psd_pkg::LENGTH_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             step,
   input  wire logic [psd_pkg::BYTE_WIDTH-1:0]   data_byte,
   output      logic                             result_valid,
   output      psd_pkg::result_type              result
);

   typedef enum logic {
      PHASE_PREFIX,
      PHASE_TEXT
   } phase_type;

   phase_type                              phase_ff, phase_in;
   logic [LENGTH_WIDTH-1:0]                length_ff, length_in;
   logic [psd_pkg::SHIFT_WIDTH-1:0]        shift_ff, shift_in;
   logic [LENGTH_WIDTH-1:0]                remaining_ff, remaining_in;
   logic [psd_pkg::CODE_WIDTH-1:0]         char_ff, char_in;
   logic [psd_pkg::PENDING_BITS-1:0]       pending_ff, pending_in;

   logic [psd_pkg::CODE_WIDTH-1:0]         prefix_bits;
   logic [LENGTH_WIDTH-1:0]                length_sum;
   logic [LENGTH_WIDTH-1:0]                remaining_dec;
   logic [3:0]                             ones;
   logic                                   is_last;

   // Count leading ones of a lead byte (1 to 8 when the top bit is set)
   function automatic logic [3:0] lead_ones(input logic [psd_pkg::BYTE_WIDTH-1:0] b);
      logic [3:0] n;
      logic       run;
      n   = 4'd0;
      run = 1'b1;
      for (int i = psd_pkg::BYTE_WIDTH - 1; i >= 0; i--) begin
         if (run && b[i]) begin
            n = n + 4'd1;
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

   // Place the 7 prefix payload bits; positions at 32 and above drop out
   always_comb begin
      prefix_bits = '0;
      if (!shift_ff[psd_pkg::SHIFT_WIDTH-1]) begin
         prefix_bits = psd_pkg::CODE_WIDTH'({data_byte[6:0]}) << shift_ff[4:0];
      end
   end

   assign length_sum    = length_ff | prefix_bits[LENGTH_WIDTH-1:0];
   assign remaining_dec = (remaining_ff != '0) ? remaining_ff - LENGTH_WIDTH'(1) : '0;
   assign ones          = lead_ones(data_byte);
   assign is_last       = (remaining_dec == '0);

   // Next state and result for one byte
   always_comb begin
      phase_in     = phase_ff;
      length_in    = length_ff;
      shift_in     = shift_ff;
      remaining_in = remaining_ff;
      char_in      = char_ff;
      pending_in   = pending_ff;
      result_valid = 1'b0;
      result       = '0;

      unique case (phase_ff)
         PHASE_PREFIX: begin
            length_in = length_sum;
            shift_in  = (shift_ff > psd_pkg::SHIFT_LIMIT) ? psd_pkg::SHIFT_SAT
                                                         : shift_ff + psd_pkg::SHIFT_STEP;
            if (!data_byte[7]) begin
               if (length_sum == '0) begin
                  // Empty string: one flagged result, restart prefix
                  length_in           = '0;
                  shift_in            = '0;
                  result_valid        = 1'b1;
                  result.last_char    = 1'b1;
                  result.empty_string = 1'b1;
               end else begin
                  remaining_in = length_sum;
                  phase_in     = PHASE_TEXT;
                  char_in      = '0;
                  pending_in   = '0;
               end
            end
         end
         PHASE_TEXT: begin
            remaining_in = remaining_dec;
            if (pending_ff == '0) begin
               if (data_byte[7]) begin
                  char_in    = psd_pkg::CODE_WIDTH'(data_byte & (8'hFF >> ones));
                  pending_in = psd_pkg::PENDING_BITS'(ones - 4'd1);
               end else begin
                  char_in    = psd_pkg::CODE_WIDTH'(data_byte);
               end
            end else begin
               char_in    = {char_ff[psd_pkg::CODE_WIDTH-psd_pkg::CONT_BITS-1:0],
                             data_byte[psd_pkg::CONT_BITS-1:0]};
               pending_in = pending_ff - psd_pkg::PENDING_BITS'(1);
            end
            if (pending_in == '0) begin
               result_valid      = 1'b1;
               result.code_point = char_in;
               result.last_char  = is_last;
               if (is_last) begin
                  phase_in  = PHASE_PREFIX;
                  length_in = '0;
                  shift_in  = '0;
               end
            end
         end
         default: begin
            phase_in = PHASE_PREFIX;
         end
      endcase
   end

   // Hold decoder state; advance on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_PREFIX;
         length_ff    <= '0;
         shift_ff     <= '0;
         remaining_ff <= '0;
         char_ff      <= '0;
         pending_ff   <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         length_ff    <= length_in;
         shift_ff     <= shift_in;
         remaining_ff <= remaining_in;
         char_ff      <= char_in;
         pending_ff   <= pending_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/psd_outbuf.sv
// Result register with one skid entry between the decoder and the result channel.
`timescale 1ns / 1ps
`default_nettype none

module psd_outbuf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire psd_pkg::result_type push_data,
   output      logic                full,
   output      logic                out_valid,
   input  wire logic                out_stall,
   output      psd_pkg::result_type out_data
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   psd_pkg::result_type main_ff, main_in;
   psd_pkg::result_type skid_ff, skid_in;
   logic                take;

   assign take      = main_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Refill main from skid first, otherwise from the new result
   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || take) begin
         main_valid_in = skid_valid_ff || push;
         main_in       = skid_valid_ff ? skid_ff : push_data;
         skid_valid_in = skid_valid_ff && push;
         skid_in       = push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

FILE: sv/psd_checker.sv
// Port-level assertions for the prefixed UTF-8 string decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module psd_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [psd_pkg::CODE_WIDTH-1:0]   rsp_code_point,
   input wire logic                             rsp_last_char,
   input wire logic                             rsp_empty_string
);

   // Reset empties the result buffer
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response or stall left after reset");

   // An empty-string response ends the string and carries no character
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_string |-> rsp_last_char && rsp_code_point == '0)
      else $error("malformed empty-string response");

   // The request side stalls only while a response is waiting
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   // A new response follows an accepted request
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("response appeared without an accepted request");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_point)
         && $stable(rsp_last_char) && $stable(rsp_empty_string))
      else $error("stalled response changed");

endmodule

bind prefixed_utf8_string_decoder psd_checker u_psd_checker (.*);

`default_nettype wire
